// ===== design/mma_pkg.sv =====
// Shared constants, types and helpers of the multichannel moving average unit.
`timescale 1ns / 1ps
package mma_pkg;

  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int NUM_CH       = 7;
  localparam int WIN_W        = 6;
  localparam int WIN_RESET    = 4;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int STEP_W = $clog2(SUM_W);
  localparam int ROW_W  = NUM_CH * SAMPLE_WIDTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;

  // Map the window register onto 1..MAX_WINDOW.
  function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [CNT_W-1:0] n;
    if (w == '0) begin
      n = CNT_W'(1);
    end else if (int'(w) > MAX_WINDOW) begin
      n = CNT_W'(MAX_WINDOW);
    end else begin
      n = CNT_W'(w);
    end
    return n;
  endfunction

endpackage

// ===== design/mma_ifs.sv =====
// Valid/ready channel interfaces for sensor frames and averaged frames.
`timescale 1ns / 1ps
interface mma_frame_if;
  import mma_pkg::*;
  logic    valid;
  logic    ready;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  sample_t temperature;
  sample_t gyro_x;
  sample_t gyro_y;
  sample_t gyro_z;
  modport source (output valid, accel_x, accel_y, accel_z, temperature,
                  gyro_x, gyro_y, gyro_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, temperature,
                gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface mma_avg_if;
  import mma_pkg::*;
  logic    valid;
  logic    ready;
  sample_t avg_accel_x;
  sample_t avg_accel_y;
  sample_t avg_accel_z;
  sample_t avg_temperature;
  sample_t avg_gyro_x;
  sample_t avg_gyro_y;
  sample_t avg_gyro_z;
  modport source (output valid, avg_accel_x, avg_accel_y, avg_accel_z, avg_temperature,
                  avg_gyro_x, avg_gyro_y, avg_gyro_z, input ready);
  modport sink (input valid, avg_accel_x, avg_accel_y, avg_accel_z, avg_temperature,
                avg_gyro_x, avg_gyro_y, avg_gyro_z, output ready);
endinterface

// ===== design/mma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/mma_divider.sv =====
// Seven-lane bit-serial restoring divider, signed dividend truncated toward zero.
`timescale 1ns / 1ps
module mma_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mma_pkg::CNT_W-1:0] divisor_i,
  input  mma_pkg::sum_t             dividend_i [mma_pkg::NUM_CH],
  output logic                      done_o,
  output mma_pkg::sample_t          quot_o [mma_pkg::NUM_CH]
);
  import mma_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  div_q;
  logic [SUM_W-1:0]  work_q [NUM_CH];
  logic [SUM_W-1:0]  work_d [NUM_CH];
  logic [CNT_W-1:0]  rem_q  [NUM_CH];
  logic [CNT_W-1:0]  rem_d  [NUM_CH];
  logic              neg_q  [NUM_CH];
  logic              neg_d  [NUM_CH];
  logic [CNT_W:0]    rem_sh [NUM_CH];
  logic              ge     [NUM_CH];
  logic [SUM_W-1:0]  q_sgn  [NUM_CH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  // One quotient bit per lane per cycle; the quotient shifts into the dividend.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem_sh[c] = {rem_q[c], work_q[c][SUM_W-1]};
      ge[c]     = rem_sh[c] >= {1'b0, div_q};
      neg_d[c]  = neg_q[c];
      rem_d[c]  = rem_q[c];
      work_d[c] = work_q[c];
      if (start_i) begin
        neg_d[c]  = dividend_i[c][SUM_W-1];
        rem_d[c]  = '0;
        work_d[c] = dividend_i[c][SUM_W-1] ? -dividend_i[c] : dividend_i[c];
      end else if (busy_q) begin
        rem_d[c]  = ge[c] ? CNT_W'(rem_sh[c] - {1'b0, div_q}) : rem_sh[c][CNT_W-1:0];
        work_d[c] = {work_q[c][SUM_W-2:0], ge[c]};
      end
      q_sgn[c]  = neg_q[c] ? -work_q[c] : work_q[c];
      quot_o[c] = sample_t'(q_sgn[c][SAMPLE_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      work_q[c] <= work_d[c];
      rem_q[c]  <= rem_d[c];
      neg_q[c]  <= neg_d[c];
    end
  end

  assign done_o = done_q;
endmodule

// ===== design/multichannel_moving_average_unit.sv =====
// Top level: seven-channel simple moving average over a sensor frame history.
`timescale 1ns / 1ps
// Usage
//   frame_i carries one sensor frame a beat: three acceleration axes, temperature
//   and three angular-rate axes, 16-bit two's complement each. avg_o returns one
//   beat per frame with the seven window averages, truncated toward zero.
//   cfg_we_i/cfg_wdata_i set the window length (0 acts as 1, above 32 acts as 32);
//   write it only while no frame is in flight.
// Timing
//   A frame is held in a 32-entry history RAM. The window is read back one row a
//   cycle (one RAM read port), then a bit-serial divider yields one quotient bit
//   per cycle for all seven lanes together. The next frame is taken only once the
//   result has been loaded into the output register; one frame is in work at a time.
// Reset
//   Clear the fill count and pointers; history rows not yet written read as zero,
//   so the averages ramp up over the first frames. The window resets to 4.
// Back-pressure
//   The result sits in an output register; a new frame is accepted while it waits.
//   A second result waits in the divider until the first beat has been taken.
module multichannel_moving_average_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mma_frame_if.sink                 frame_i,
  mma_avg_if.source                 avg_o,
  input  logic                      cfg_we_i,
  input  logic [mma_pkg::WIN_W-1:0] cfg_wdata_i
);
  import mma_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } seq_state_e;

  seq_state_e       state_q, state_d;
  logic [WIN_W-1:0] win_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] rd_k_q, rd_k_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_use_q, rd_use_d;
  logic             out_valid_q;
  sample_t          avg_q [NUM_CH];
  sum_t             sum_q [NUM_CH];
  sample_t          quot  [NUM_CH];

  logic             in_fire;
  logic             ram_we, ram_re;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic             clr_sum, div_start, div_done, load_out;

  assign frame_i.ready = (state_q == ST_IDLE);
  assign in_fire       = frame_i.valid && frame_i.ready;

  // Pack the frame into one history row, channel 0 in the low bits.
  assign ram_wdata = {frame_i.gyro_z, frame_i.gyro_y, frame_i.gyro_x, frame_i.temperature,
                      frame_i.accel_z, frame_i.accel_y, frame_i.accel_x};
  assign ram_waddr = head_q + 1'b1;
  // Walk back from the newest row; the pointer wraps round the buffer.
  assign ram_raddr = head_q - rd_k_q[PTR_W-1:0];

  mma_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    n_d       = n_q;
    rd_k_d    = rd_k_q;
    rd_vld_d  = 1'b0;
    rd_use_d  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    clr_sum   = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ram_we  = 1'b1;
          head_d  = head_q + 1'b1;
          if (fill_q != CNT_W'(MAX_WINDOW)) begin
            fill_d = fill_q + 1'b1;
          end
          n_d     = eff_window(win_q);
          rd_k_d  = '0;
          clr_sum = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_k_q != n_q) begin
          // Rows never written since reset count as zero.
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_use_d = rd_k_q < fill_q;
          rd_k_d   = rd_k_q + 1'b1;
        end else if (!rd_vld_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // Hold the quotients until the output register is free.
        if (!out_valid_q || avg_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_W'(WIN_RESET);
      head_q      <= '0;
      fill_q      <= '0;
      n_q         <= CNT_W'(1);
      rd_k_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_use_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      n_q      <= n_d;
      rd_k_q   <= rd_k_d;
      rd_vld_q <= rd_vld_d;
      rd_use_q <= rd_use_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (avg_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Accumulate one history row per cycle, seven lanes side by side.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (clr_sum) begin
        sum_q[c] <= '0;
      end else if (rd_vld_q && rd_use_q) begin
        sum_q[c] <= sum_q[c] + sum_t'(sample_t'(ram_rdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
      end
      if (load_out) begin
        avg_q[c] <= quot[c];
      end
    end
  end

  mma_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (n_q),
    .dividend_i (sum_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign avg_o.valid           = out_valid_q;
  assign avg_o.avg_accel_x     = avg_q[0];
  assign avg_o.avg_accel_y     = avg_q[1];
  assign avg_o.avg_accel_z     = avg_q[2];
  assign avg_o.avg_temperature = avg_q[3];
  assign avg_o.avg_gyro_x      = avg_q[4];
  assign avg_o.avg_gyro_y      = avg_q[5];
  assign avg_o.avg_gyro_z      = avg_q[6];
endmodule

// ===== design/mma_checker.sv =====
// Port-level checker for the moving average unit, bound to the top level.
`timescale 1ns / 1ps
module mma_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [mma_pkg::ROW_W-1:0] out_data_i
);
  import mma_pkg::*;

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result payload changed while stalled");

  // Drop ready once a frame is taken: one frame is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("frame accepted while another is in work");

  // A new result only emerges from a frame in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared with no frame in work");
endmodule

bind multichannel_moving_average_unit mma_checker u_mma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (frame_i.valid),
  .in_ready_i  (frame_i.ready),
  .out_valid_i (avg_o.valid),
  .out_ready_i (avg_o.ready),
  .out_data_i  ({avg_o.avg_gyro_z, avg_o.avg_gyro_y, avg_o.avg_gyro_x, avg_o.avg_temperature,
                 avg_o.avg_accel_z, avg_o.avg_accel_y, avg_o.avg_accel_x})
);

// ===== sim/tb_multichannel_moving_average_unit.sv =====
// Testbench for the seven-channel moving average unit: directed script, then random frames.
`timescale 1ns / 1ps
module tb_multichannel_moving_average_unit;
  import mma_pkg::*;

  // One frame as seven lanes, index 0 = accel_x up to index 6 = gyro_z.
  typedef sample_t [0:NUM_CH-1] chan_row_t;

  typedef enum logic {STEP_FRAME, STEP_WINDOW} step_e;

  // One row of the directed script: a frame beat or a window write.
  typedef struct packed {
    step_e            kind;
    logic [WIN_W-1:0] win;
    chan_row_t        samples;
    logic             typed;
    chan_row_t        want;
  } script_row_t;

  localparam int      HALF_PERIOD_NS   = 6;
  localparam int      TIMEOUT_NS       = 15_000_000;
  localparam int      SETTLE_CYCLES    = 4;
  localparam int      DRAIN_CYCLES     = 64;
  localparam int      HOLD_CYCLES      = 400;
  localparam int      PHASES           = 14;
  localparam int      FIXED_PHASES     = 12;
  localparam int      FRAMES_PER_PHASE = 82;
  localparam int      MAX_REPORTS      = 40;
  localparam sample_t S_MAX            = 16'sh7FFF;
  localparam sample_t S_MIN            = 16'sh8000;

  // Window settings of the random phases; the last phases pick one at random.
  localparam logic [WIN_W-1:0] PHASE_WINDOW [FIXED_PHASES] = '{
    6'd4, 6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd17, 6'd33, 6'd8, 6'd31, 6'd3, 6'd5
  };

  // Directed script. Expected averages are typed in where they follow at a glance
  // (ramp-up after reset, full-scale extremes, window of one, truncation toward
  // zero); the remaining frame rows go through the predictor.
  localparam int SCRIPT_LEN = 22;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // ramp-up from the cleared history at the reset window of four
    '{STEP_FRAME, 6'd0, '{default: S_MAX}, 1'b1, '{default: 16'sd8191}},
    '{STEP_FRAME, 6'd0, '{default: S_MIN}, 1'b1, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0, '{default: S_MIN}, 1'b1, '{default: -16'sd8192}},
    '{STEP_FRAME, 6'd0, '{default: S_MIN}, 1'b1, '{default: -16'sd16384}},
    '{STEP_FRAME, 6'd0, '{default: S_MIN}, 1'b1, '{default: S_MIN}},
    // zero window acts as one: the frame comes straight back
    '{STEP_WINDOW, 6'd0, '{default: 16'sd0}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0,
      '{16'sd1, -16'sd1, S_MAX, S_MIN, 16'sd0, 16'sd12345, -16'sd12345}, 1'b1,
      '{16'sd1, -16'sd1, S_MAX, S_MIN, 16'sd0, 16'sd12345, -16'sd12345}},
    // oversized window saturates to the full delay line
    '{STEP_WINDOW, 6'd63, '{default: 16'sd0}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0, '{default: S_MAX}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0, '{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX}, 1'b0,
      '{default: 16'sd0}},
    '{STEP_WINDOW, 6'd32, '{default: 16'sd0}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0,
      '{-16'sd1000, 16'sd2000, -16'sd3000, 16'sd4000, -16'sd5000, 16'sd6000, -16'sd7000},
      1'b0, '{default: 16'sd0}},
    '{STEP_WINDOW, 6'd33, '{default: 16'sd0}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0, '{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN}, 1'b0,
      '{default: 16'sd0}},
    // truncation toward zero: (-2 + -3) / 2 gives -2, (5 + -2) / 2 gives 1
    '{STEP_WINDOW, 6'd1, '{default: 16'sd0}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0, '{default: -16'sd3}, 1'b1, '{default: -16'sd3}},
    '{STEP_WINDOW, 6'd2, '{default: 16'sd0}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0, '{default: -16'sd2}, 1'b1, '{default: -16'sd2}},
    '{STEP_FRAME, 6'd0, '{default: 16'sd5}, 1'b1, '{default: 16'sd1}},
    // window grows again: the average reaches back into older history
    '{STEP_WINDOW, 6'd3, '{default: 16'sd0}, 1'b0, '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0,
      '{-16'sd7, 16'sd7, -16'sd1, 16'sd1, 16'sd100, -16'sd100, 16'sd0}, 1'b0,
      '{default: 16'sd0}},
    '{STEP_FRAME, 6'd0,
      '{-16'sd8, 16'sd8, -16'sd2, 16'sd2, -16'sd101, 16'sd101, 16'sd1}, 1'b0,
      '{default: 16'sd0}}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;

  mma_frame_if frame_bus ();
  mma_avg_if   avg_bus ();

  multichannel_moving_average_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .frame_i     (frame_bus),
    .avg_o       (avg_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor state: its own delay line and window register.
  chan_row_t        history [MAX_WINDOW];
  logic [WIN_W-1:0] window_reg;
  chan_row_t        avg_expected_q [$];

  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned directed_frames;
  int unsigned random_frames;
  int unsigned windows_written;
  int unsigned hold_offs_done;
  bit          hold_off_req;

  string lane_label [NUM_CH] = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                                 "avg_temperature", "avg_gyro_x", "avg_gyro_y",
                                 "avg_gyro_z"};

  // Clock: high phase, then low phase.
  always begin
    #HALF_PERIOD_NS clk = 1'b1;
    #HALF_PERIOD_NS clk = 1'b0;
  end

  // Shift the delay line, store the frame at the front and average the newest
  // entries of every lane. Signed division in SystemVerilog truncates toward zero.
  function automatic chan_row_t average_frame(input chan_row_t frame);
    int        span;
    longint    total;
    chan_row_t avg;
    if (window_reg == '0) begin
      span = 1;
    end else if (int'(window_reg) > MAX_WINDOW) begin
      span = MAX_WINDOW;
    end else begin
      span = int'(window_reg);
    end
    for (int i = MAX_WINDOW - 1; i > 0; i--) begin
      history[i] = history[i-1];
    end
    history[0] = frame;
    for (int c = 0; c < NUM_CH; c++) begin
      total = 0;
      for (int k = 0; k < span; k++) begin
        total += longint'($signed(history[k][c]));
      end
      avg[c] = sample_t'(total / longint'(span));
    end
    return avg;
  endfunction

  // Pick one lane value: wide random half the time, with extremes and small values
  // mixed in so that sums near both ends and near zero turn up often.
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 7))
      0:       s = S_MAX;
      1:       s = S_MIN;
      2, 3:    s = sample_t'($signed($urandom_range(0, 128)) - 64);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic chan_row_t random_frame();
    chan_row_t f;
    for (int c = 0; c < NUM_CH; c++) begin
      f[c] = random_sample();
    end
    return f;
  endfunction

  // Offer one frame beat and hold it until taken; on acceptance, advance the
  // predictor and queue either the typed-in or the predicted averages.
  task automatic push_frame(input chan_row_t frame, input logic typed,
                            input chan_row_t want);
    chan_row_t predicted;
    @(negedge clk);
    frame_bus.valid       <= 1'b1;
    frame_bus.accel_x     <= frame[0];
    frame_bus.accel_y     <= frame[1];
    frame_bus.accel_z     <= frame[2];
    frame_bus.temperature <= frame[3];
    frame_bus.gyro_x      <= frame[4];
    frame_bus.gyro_y      <= frame[5];
    frame_bus.gyro_z      <= frame[6];
    do @(posedge clk); while (!frame_bus.ready);
    predicted = average_frame(frame);
    avg_expected_q.push_back(typed ? want : predicted);
  endtask

  // Drop valid for a number of cycles.
  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      frame_bus.valid <= 1'b0;
    end
  endtask

  // Write the window only once the unit has drained and settled.
  task automatic set_window(input logic [WIN_W-1:0] win);
    idle_sender(1);
    while (avg_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= win;
    @(negedge clk);
    cfg_we    <= 1'b0;
    window_reg = win;
    windows_written++;
  endtask

  // Receiver pacing: spans of always-ready, light and heavy random stalls and a
  // fixed stall pattern; on request, a long hold-off so that the unit fills up
  // and has to stall its frame input.
  initial begin : sink_pace
    int unsigned mode;
    int unsigned span;
    logic [7:0]  pattern;
    avg_bus.ready = 1'b0;
    forever begin
      if (hold_off_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          avg_bus.ready <= 1'b0;
        end
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else begin
        mode    = $urandom_range(0, 3);
        span    = $urandom_range(8, 64);
        pattern = 8'($urandom);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0:       avg_bus.ready <= 1'b1;
            1:       avg_bus.ready <= ($urandom_range(0, 3) != 0);
            2:       avg_bus.ready <= 1'($urandom_range(0, 1));
            default: begin
              avg_bus.ready <= pattern[0];
              pattern = {pattern[0], pattern[7:1]};
            end
          endcase
        end
      end
    end
  end

  // Check every result beat against the oldest expectation, lane by lane.
  always @(posedge clk) begin : avg_check
    chan_row_t got;
    chan_row_t want;
    if (rst_n === 1'b1 && avg_bus.valid === 1'b1 && avg_bus.ready === 1'b1) begin
      got = '{avg_bus.avg_accel_x, avg_bus.avg_accel_y, avg_bus.avg_accel_z,
              avg_bus.avg_temperature, avg_bus.avg_gyro_x, avg_bus.avg_gyro_y,
              avg_bus.avg_gyro_z};
      results_seen++;
      if (avg_expected_q.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $error("averaged beat with no frame outstanding");
        end
        fail_count++;
      end else begin
        want = avg_expected_q.pop_front();
        for (int c = 0; c < NUM_CH; c++) begin
          if (got[c] !== want[c]) begin
            if (fail_count < MAX_REPORTS) begin
              $error("%s: expected %0d, got %0d", lane_label[c],
                     $signed(want[c]), $signed(got[c]));
            end
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus: reset, directed script, then random phases at several windows.
  initial begin : stimulus
    int unsigned burst_left;
    int unsigned gap;
    logic [WIN_W-1:0] win;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    frame_bus.valid       = 1'b0;
    frame_bus.accel_x     = '0;
    frame_bus.accel_y     = '0;
    frame_bus.accel_z     = '0;
    frame_bus.temperature = '0;
    frame_bus.gyro_x      = '0;
    frame_bus.gyro_y      = '0;
    frame_bus.gyro_z      = '0;
    fail_count      = 0;
    results_seen    = 0;
    directed_frames = 0;
    random_frames   = 0;
    windows_written = 0;
    hold_offs_done  = 0;
    hold_off_req    = 1'b0;
    window_reg      = WIN_W'(WIN_RESET);
    for (int i = 0; i < MAX_WINDOW; i++) begin
      history[i] = '{default: 16'sd0};
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].kind == STEP_WINDOW) begin
        set_window(SCRIPT[r].win);
      end else begin
        push_frame(SCRIPT[r].samples, SCRIPT[r].typed, SCRIPT[r].want);
        directed_frames++;
      end
    end

    // Random phases: bursts of back-to-back beats separated by gaps of random
    // length, so that idle cycles land on every step of the divider.
    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      win = (p < FIXED_PHASES) ? PHASE_WINDOW[p] : WIN_W'($urandom_range(0, 63));
      set_window(win);
      if (p == 2 || p == 9) begin
        hold_off_req = 1'b1;
      end
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
          idle_sender(gap);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
        end
        push_frame(random_frame(), 1'b0, '{default: 16'sd0});
        burst_left--;
        random_frames++;
      end
    end

    // Drain: wait for the last averages, then watch for stray beats.
    idle_sender(1);
    while (avg_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d directed and %0d random frames, %0d averaged beats checked,",
             directed_frames, random_frames, results_seen);
    $display("%0d window writes (0, 1, 32, 33, 63 among them), %0d long sink hold-offs.",
             windows_written, hold_offs_done);
    if (fail_count == 0) begin
      $display("tb_multichannel_moving_average_unit OK");
    end else begin
      $display("tb_multichannel_moving_average_unit NOT OK");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("tb_multichannel_moving_average_unit NOT OK");
    $finish;
  end

endmodule
